### hdl/ic72_pkg.sv
// ic72_pkg: shared types, codes and helper functions for the 72-source interrupt controller
// no dependencies; imported by every module of the block

package ic72_pkg;

    // operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // register map
    localparam logic [3:0] REG_BASIC_PEND   = 4'd0;
    localparam logic [3:0] REG_PEND_LOW     = 4'd1;
    localparam logic [3:0] REG_PEND_HIGH    = 4'd2;
    localparam logic [3:0] REG_FIQ_CTRL     = 4'd3;
    localparam logic [3:0] REG_ENABLE_LOW   = 4'd4;
    localparam logic [3:0] REG_ENABLE_HIGH  = 4'd5;
    localparam logic [3:0] REG_ENABLE_BASIC = 4'd6;
    localparam logic [3:0] REG_DISABLE_LOW  = 4'd7;
    localparam logic [3:0] REG_DISABLE_HIGH = 4'd8;
    localparam logic [3:0] REG_DISABLE_BASIC = 4'd9;

    localparam int NUM_SHORTCUT = 11;

    // peripheral numbers mirrored into basic pending bits 10 to 20
    localparam logic [5:0] SHORTCUT_SRC [NUM_SHORTCUT] = '{
        6'd7, 6'd9, 6'd10, 6'd18, 6'd19, 6'd53,
        6'd54, 6'd55, 6'd56, 6'd57, 6'd62
    };

    localparam logic [6:0] PERIPH_LOW_BASE  = 7'd8;
    localparam logic [6:0] PERIPH_HIGH_BASE = 7'd40;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  reg_select;
        logic [31:0] write_data;
        logic [7:0]  basic_lines;
        logic [31:0] periph_lines_low;
        logic [31:0] periph_lines_high;
    } req_item_t;

    typedef struct packed {
        logic [7:0]  basic_enable;
        logic [31:0] periph_enable_low;
        logic [31:0] periph_enable_high;
        logic [7:0]  basic_level;
        logic [31:0] periph_level_low;
        logic [31:0] periph_level_high;
    } ic_state_t;

    typedef struct packed {
        logic       irq_out;
        logic [6:0] vector;
        logic       vector_valid;
    } prio_status_t;

    // index of the lowest set bit, zero for an all-zero word
    function automatic logic [4:0] lowest_bit32(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) idx = i[4:0];
        end
        return idx;
    endfunction

    // basic pending word as seen by the driver
    function automatic logic [31:0] basic_word(input ic_state_t st);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] pend;
        logic [31:0] w;
        lo   = st.periph_level_low & st.periph_enable_low;
        hi   = st.periph_level_high & st.periph_enable_high;
        pend = {hi, lo};
        w    = '0;
        w[7:0] = st.basic_level & st.basic_enable;
        w[8]   = |lo;
        w[9]   = |hi;
        for (int i = 0; i < NUM_SHORTCUT; i++) begin
            w[10 + i] = pend[SHORTCUT_SRC[i]];
        end
        return w;
    endfunction

endpackage

### hdl/ic72_req_if.sv
// ic72_req_if: request channel (register access or line sample) with valid/ready
// no dependencies

interface ic72_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
    logic [7:0]  basic_lines;
    logic [31:0] periph_lines_low;
    logic [31:0] periph_lines_high;

    modport source (
        output valid, operation, reg_select, write_data,
               basic_lines, periph_lines_low, periph_lines_high,
        input  ready
    );

    modport sink (
        input  valid, operation, reg_select, write_data,
               basic_lines, periph_lines_low, periph_lines_high,
        output ready
    );
endinterface

### hdl/ic72_rsp_if.sv
// ic72_rsp_if: result channel (read data, interrupt and vector) with valid/ready
// no dependencies

interface ic72_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_out;
    logic [6:0]  vector;
    logic        vector_valid;

    modport source (
        output valid, read_data, irq_out, vector, vector_valid,
        input  ready
    );

    modport sink (
        input  valid, read_data, irq_out, vector, vector_valid,
        output ready
    );
endinterface

### hdl/interrupt_controller_72_source_top.sv
// interrupt_controller_72_source_top: level-sensitive controller for 8 basic and 64 peripheral sources
// depends on ic72_pkg, ic72_req_if, ic72_rsp_if, ic72_regs, ic72_prio
//
//  channel | modport | payload                                              | transfer when
//  --------+---------+------------------------------------------------------+---------------
//  req     | sink    | operation reg_select write_data basic_lines          | valid & ready
//          |         | periph_lines_low periph_lines_high                   |
//  rsp     | source  | read_data irq_out vector vector_valid                | valid & ready
//
// one request per cycle sustained while rsp is ready; a request lands in the input
// register at its transfer, then moves on to the result register, which offers its
// result until the rsp transfer; a stalled rsp keeps the item in the input register
// the state update and priority encode sit between the two registers
// a stalled rsp holds the result register; the input register keeps taking a new
// request as long as its item can move on in the same cycle, so two requests wait at most
// reset clears the enable masks, the latched levels and both valid flags

module interrupt_controller_72_source_top (
    input  logic        clk,
    input  logic        rst_n,
    ic72_req_if.sink    req,
    ic72_rsp_if.source  rsp
);
    import ic72_pkg::*;

    // input stage
    req_item_t    in_item_reg;
    logic         in_valid_reg;

    // result stage
    logic [31:0]  read_data_reg;
    prio_status_t status_reg;
    logic         out_valid_reg;

    logic         adv;
    ic_state_t    state_next;
    logic [31:0]  read_data;
    prio_status_t status;

    // the held item moves to the result register when that slot is free or draining
    assign adv       = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.operation         <= req.operation;
            in_item_reg.reg_select        <= req.reg_select;
            in_item_reg.write_data        <= req.write_data;
            in_item_reg.basic_lines       <= req.basic_lines;
            in_item_reg.periph_lines_low  <= req.periph_lines_low;
            in_item_reg.periph_lines_high <= req.periph_lines_high;
        end
    end

    // masks and levels; state commits only when the item advances
    ic72_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item       (in_item_reg),
        .state_next (state_next),
        .read_data  (read_data)
    );

    // irq and vector see the item's own write or sample
    ic72_prio u_prio (
        .st     (state_next),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            read_data_reg <= read_data;
            status_reg    <= status;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = read_data_reg;
    assign rsp.irq_out      = status_reg.irq_out;
    assign rsp.vector       = status_reg.vector;
    assign rsp.vector_valid = status_reg.vector_valid;
endmodule

### hdl/ic72_regs.sv
// ic72_regs: enable masks and latched source levels, update and register read mux
// depends on ic72_pkg

module ic72_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  ic72_pkg::req_item_t   item,
    output ic72_pkg::ic_state_t   state_next,
    output logic [31:0]           read_data
);
    import ic72_pkg::*;

    ic_state_t state_reg;

    always_comb
    begin
        state_next = state_reg;
        case (item.operation)
            OP_WRITE:
            begin
                case (item.reg_select)
                    REG_ENABLE_LOW:
                        state_next.periph_enable_low =
                            state_reg.periph_enable_low | item.write_data;
                    REG_ENABLE_HIGH:
                        state_next.periph_enable_high =
                            state_reg.periph_enable_high | item.write_data;
                    REG_ENABLE_BASIC:
                        state_next.basic_enable =
                            state_reg.basic_enable | item.write_data[7:0];
                    REG_DISABLE_LOW:
                        state_next.periph_enable_low =
                            state_reg.periph_enable_low & ~item.write_data;
                    REG_DISABLE_HIGH:
                        state_next.periph_enable_high =
                            state_reg.periph_enable_high & ~item.write_data;
                    REG_DISABLE_BASIC:
                        state_next.basic_enable =
                            state_reg.basic_enable & ~item.write_data[7:0];
                    default: ;
                endcase
            end
            OP_SAMPLE:
            begin
                state_next.basic_level      = item.basic_lines;
                state_next.periph_level_low  = item.periph_lines_low;
                state_next.periph_level_high = item.periph_lines_high;
            end
            default: ;
        endcase
    end

    // reads never change state, so the current state serves
    always_comb
    begin
        read_data = '0;
        if (item.operation == OP_READ)
        begin
            case (item.reg_select)
                REG_BASIC_PEND:
                    read_data = basic_word(state_reg);
                REG_PEND_LOW:
                    read_data = state_reg.periph_level_low & state_reg.periph_enable_low;
                REG_PEND_HIGH:
                    read_data = state_reg.periph_level_high & state_reg.periph_enable_high;
                REG_ENABLE_LOW, REG_DISABLE_LOW:
                    read_data = state_reg.periph_enable_low;
                REG_ENABLE_HIGH, REG_DISABLE_HIGH:
                    read_data = state_reg.periph_enable_high;
                REG_ENABLE_BASIC, REG_DISABLE_BASIC:
                    read_data = {24'd0, state_reg.basic_enable};
                default:
                    read_data = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (adv)
            state_reg <= state_next;
    end
endmodule

### hdl/ic72_prio.sv
// ic72_prio: pending summary and priority vector from the updated state
// depends on ic72_pkg

module ic72_prio (
    input  ic72_pkg::ic_state_t    st,
    output ic72_pkg::prio_status_t status
);
    import ic72_pkg::*;

    logic [31:0] bw;
    logic [31:0] pend_lo;
    logic [31:0] pend_hi;
    logic [NUM_SHORTCUT-1:0] sc;
    logic [3:0]  sc_idx;
    logic [4:0]  basic_idx;
    logic [4:0]  lo_idx;
    logic [4:0]  hi_idx;

    assign bw      = basic_word(st);
    assign pend_lo = st.periph_level_low & st.periph_enable_low;
    assign pend_hi = st.periph_level_high & st.periph_enable_high;
    assign sc      = bw[10 +: NUM_SHORTCUT];

    assign basic_idx = lowest_bit32({24'd0, bw[7:0]});
    assign lo_idx    = lowest_bit32(pend_lo);
    assign hi_idx    = lowest_bit32(pend_hi);

    always_comb
    begin
        sc_idx = '0;
        for (int i = NUM_SHORTCUT - 1; i >= 0; i--) begin
            if (sc[i]) sc_idx = i[3:0];
        end
    end

    always_comb
    begin
        status.irq_out      = |bw;
        status.vector_valid = 1'b1;
        if (|bw[7:0])
            status.vector = {4'd0, basic_idx[2:0]};
        else if (|sc)
            status.vector = {1'b0, SHORTCUT_SRC[sc_idx]} + PERIPH_LOW_BASE;
        else if (bw[8])
            status.vector = {2'd0, lo_idx} + PERIPH_LOW_BASE;
        else if (bw[9])
            status.vector = {2'd0, hi_idx} + PERIPH_HIGH_BASE;
        else
        begin
            status.vector       = '0;
            status.vector_valid = 1'b0;
        end
    end
endmodule
